FILE: rtl/core/midi_byte_stream_parser_unit_assert.svh
// Assertion macros shared by the MIDI byte stream parser RTL.
`ifndef MIDI_BYTE_STREAM_PARSER_UNIT_ASSERT_SVH
`define MIDI_BYTE_STREAM_PARSER_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MBSP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MBSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/mbsp_pkg.sv
// Types, codes and constants of the MIDI byte stream parser.
package mbsp_pkg;

   localparam int SYSEX_CAPACITY = 256;
   localparam int SX_CNT_W       = $clog2(SYSEX_CAPACITY + 1);
   localparam int SX_IDX_W       = 9;

   localparam logic [2:0] EV_CLOCK   = 3'd0;
   localparam logic [2:0] EV_START   = 3'd1;
   localparam logic [2:0] EV_STOP    = 3'd2;
   localparam logic [2:0] EV_SX_BYTE = 3'd3;
   localparam logic [2:0] EV_SX_END  = 3'd4;
   localparam logic [2:0] EV_NOTE    = 3'd5;
   localparam logic [2:0] EV_PROG    = 3'd6;

   localparam logic [7:0] BYTE_CLOCK    = 8'hF8;
   localparam logic [7:0] BYTE_START    = 8'hFA;
   localparam logic [7:0] BYTE_CONTINUE = 8'hFB;
   localparam logic [7:0] BYTE_STOP     = 8'hFC;
   localparam logic [7:0] BYTE_SX_START = 8'hF0;
   localparam logic [7:0] BYTE_SX_END   = 8'hF7;
   localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
   localparam logic [3:0] TYPE_CC       = 4'hB;
   localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
   localparam logic [3:0] TYPE_PRESSURE = 4'hD;
   localparam logic [7:0] CC_BANK_LSB   = 8'd32;
   localparam logic [6:0] ACCENT_VEL    = 7'd100;
   localparam logic [7:0] BANK_NONE     = 8'hFF;

   localparam logic REG_LISTEN_CHANNEL = 1'b0;
   localparam logic REG_FORWARD_CLOCK  = 1'b1;

   typedef struct packed {
      logic                in_sysex;
      logic [SX_CNT_W-1:0] sysex_count;
      logic [7:0]          running_status;
      logic                data_count;
      logic [7:0]          first_data;
      logic [7:0]          bank_low;
      logic                transport;
   } state_type;

   typedef struct packed {
      logic [2:0]          event_res;
      logic [7:0]          data_value;
      logic [6:0]          velocity;
      logic                accent;
      logic                variation;
      logic [SX_IDX_W-1:0] sysex_index;
      logic                transport;
      logic                echo_clock;
   } result_type;

endpackage

FILE: rtl/core/midi_byte_stream_parser_unit.sv
// Top level of the MIDI byte stream parser: input stage, state, result register, CSRs.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_valid / req_ready   req_rx_value
//   rsp      out        rsp_valid / rsp_ready   rsp_event_res .. rsp_echo_clock
//   csr      in         APB, pready tied high   listen_channel @0x0, forward_clock @0x4
//
// One item per cycle is accepted while the stage is empty or advancing; its result, if any, is loaded when it advances.
// The stage register decodes against the parser state and loads the result register.
// A stalled result holds the stage only when the staged item also produces a result.
// Reset is synchronous and resets the state (no bank stored), the CSRs and all valid flags.
`include "midi_byte_stream_parser_unit_assert.svh"

module midi_byte_stream_parser_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_rx_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_event_res,
   output logic [7:0]                     rsp_data_value,
   output logic [6:0]                     rsp_velocity,
   output logic                           rsp_accent,
   output logic                           rsp_variation,
   output logic [mbsp_pkg::SX_IDX_W-1:0]  rsp_sysex_index,
   output logic                           rsp_transport,
   output logic                           rsp_echo_clock,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import mbsp_pkg::*;

   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_byte_ff;
   state_type  state_ff, state_in;
   result_type rsp_ff, dec_result;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       dec_fire;
   logic       advance;
   logic [4:0] listen_channel_ff;
   logic       forward_clock_ff;
   logic       csr_write;

   mbsp_decode u_decode (
      .rx_byte        (stage_byte_ff),
      .state_cur      (state_ff),
      .listen_channel (listen_channel_ff),
      .forward_clock  (forward_clock_ff),
      .state_nxt      (state_in),
      .result         (dec_result),
      .fire           (dec_fire)
   );

   // An item without a result never waits on the output side.
   assign advance        = stage_valid_ff && (!dec_fire || !rsp_valid_ff || rsp_ready);
   assign req_ready      = !stage_valid_ff || advance;
   assign stage_valid_in = req_valid || (stage_valid_ff && !advance);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && dec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= '{in_sysex: 1'b0, sysex_count: '0, running_status: 8'd0,
                             data_count: 1'b0, first_data: 8'd0, bank_low: BANK_NONE,
                             transport: 1'b0};
      end else begin
         if (req_ready) begin
            stage_valid_ff <= stage_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_byte_ff <= req_rx_value;
      end
      if (advance && dec_fire) begin
         rsp_ff <= dec_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_ff.event_res;
   assign rsp_data_value  = rsp_ff.data_value;
   assign rsp_velocity    = rsp_ff.velocity;
   assign rsp_accent      = rsp_ff.accent;
   assign rsp_variation   = rsp_ff.variation;
   assign rsp_sysex_index = rsp_ff.sysex_index;
   assign rsp_transport   = rsp_ff.transport;
   assign rsp_echo_clock  = rsp_ff.echo_clock;

   // Registers sit at word addresses; the byte offset bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_channel_ff <= 5'd0;
         forward_clock_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_LISTEN_CHANNEL: listen_channel_ff <= csr_pwdata[4:0];
            REG_FORWARD_CLOCK:  forward_clock_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_LISTEN_CHANNEL: csr_prdata = {27'd0, listen_channel_ff};
         REG_FORWARD_CLOCK:  csr_prdata = {31'd0, forward_clock_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   `MBSP_ASSERT_NOW(a_vel_only_on_note,
      rsp_valid_ff && (rsp_ff.event_res != EV_NOTE),
      (rsp_ff.velocity == 7'd0) && !rsp_ff.accent,
      "velocity or accent set on an event other than note on")
   `MBSP_ASSERT_NOW(a_accent_matches_vel,
      rsp_valid_ff && rsp_ff.accent,
      rsp_ff.velocity >= ACCENT_VEL,
      "accent set with a velocity below the accent threshold")
   `MBSP_ASSERT_NOW(a_sysex_count_bound,
      1'b1,
      state_ff.sysex_count <= SX_CNT_W'(SYSEX_CAPACITY),
      "sysex count beyond capacity")
   `MBSP_ASSERT_NEXT(a_sysex_restart,
      advance && (stage_byte_ff == BYTE_SX_START),
      state_ff.in_sysex && (state_ff.sysex_count == '0),
      "sysex start did not open an empty sysex")

endmodule

FILE: rtl/core/mbsp_decode.sv
// Decode of one MIDI byte against the parser state: next state and optional event.
module mbsp_decode (
   input  logic [7:0]             rx_byte,
   input  mbsp_pkg::state_type    state_cur,
   input  logic [4:0]             listen_channel,
   input  logic                   forward_clock,
   output mbsp_pkg::state_type    state_nxt,
   output mbsp_pkg::result_type   result,
   output logic                   fire
);
   import mbsp_pkg::*;

   logic [3:0] msg_type;
   logic       need_two;
   logic [7:0] d0;
   logic       chan_ok;
   logic [6:0] prog;

   assign msg_type = state_cur.running_status[7:4];
   assign need_two = (msg_type != TYPE_PROGRAM) && (msg_type != TYPE_PRESSURE);
   assign d0       = need_two ? state_cur.first_data : rx_byte;
   assign prog     = d0[6:0];
   assign chan_ok  = (listen_channel == 5'd0) ||
                     (({1'b0, state_cur.running_status[3:0]} + 5'd1) == listen_channel);

   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      fire      = 1'b0;

      priority if (rx_byte >= BYTE_CLOCK) begin
         // Real-time bytes pass through any message, SysEx included.
         unique case (rx_byte)
            BYTE_CLOCK: begin
               fire              = 1'b1;
               result.event_res  = EV_CLOCK;
               result.echo_clock = forward_clock;
            end
            BYTE_START, BYTE_CONTINUE: begin
               fire                = 1'b1;
               result.event_res    = EV_START;
               state_nxt.transport = 1'b1;
            end
            BYTE_STOP: begin
               fire                = 1'b1;
               result.event_res    = EV_STOP;
               state_nxt.transport = 1'b0;
            end
            default: ;
         endcase
      end else if (rx_byte == BYTE_SX_START) begin
         state_nxt.in_sysex    = 1'b1;
         state_nxt.sysex_count = '0;
      end else if (rx_byte == BYTE_SX_END) begin
         state_nxt.in_sysex = 1'b0;
         if (state_cur.in_sysex) begin
            fire               = 1'b1;
            result.event_res   = EV_SX_END;
            result.sysex_index = SX_IDX_W'(state_cur.sysex_count);
         end
      end else if (state_cur.in_sysex) begin
         // Bytes past the capacity are dropped without an item.
         if (state_cur.sysex_count < SX_CNT_W'(SYSEX_CAPACITY)) begin
            fire                  = 1'b1;
            result.event_res      = EV_SX_BYTE;
            result.data_value     = rx_byte;
            result.sysex_index    = SX_IDX_W'(state_cur.sysex_count);
            state_nxt.sysex_count = state_cur.sysex_count + SX_CNT_W'(1);
         end
      end else if (rx_byte[7]) begin
         state_nxt.running_status = rx_byte;
         state_nxt.data_count     = 1'b0;
      end else if (state_cur.running_status == 8'd0) begin
         // Data with no status seen yet is ignored.
      end else if (need_two && !state_cur.data_count) begin
         state_nxt.first_data = rx_byte;
         state_nxt.data_count = 1'b1;
      end else begin
         state_nxt.data_count = 1'b0;
         if (chan_ok) begin
            if (msg_type == TYPE_NOTE_ON) begin
               if (rx_byte != 8'd0) begin
                  fire              = 1'b1;
                  result.event_res  = EV_NOTE;
                  result.data_value = d0;
                  result.velocity   = rx_byte[6:0];
                  result.accent     = rx_byte[6:0] >= ACCENT_VEL;
               end
            end else if (msg_type == TYPE_CC) begin
               if (d0 == CC_BANK_LSB) begin
                  state_nxt.bank_low = rx_byte;
               end
            end else if (msg_type == TYPE_PROGRAM) begin
               fire              = 1'b1;
               result.event_res  = EV_PROG;
               result.data_value = {4'd0, prog[3:0]};
               // A stored bank of 0 or 1 overrides the program number bit.
               result.variation  = (state_cur.bank_low <= 8'd1) ?
                                   state_cur.bank_low[0] : prog[4];
            end
         end
      end

      result.transport = state_nxt.transport;
   end

endmodule

FILE: tb/midi_byte_stream_parser_unit_test.sv
// Self-checking testbench for the MIDI byte stream parser: directed and random byte streams.
module midi_byte_stream_parser_unit_test;
   import mbsp_pkg::*;

   localparam int SETTLE_CYCLES = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_value = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_data_value;
   logic [6:0]  rsp_velocity;
   logic        rsp_accent;
   logic        rsp_variation;
   logic [SX_IDX_W-1:0] rsp_sysex_index;
   logic        rsp_transport;
   logic        rsp_echo_clock;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   midi_byte_stream_parser_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_rx_value(req_rx_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_event_res), .rsp_data_value(rsp_data_value),
      .rsp_velocity(rsp_velocity), .rsp_accent(rsp_accent),
      .rsp_variation(rsp_variation), .rsp_sysex_index(rsp_sysex_index),
      .rsp_transport(rsp_transport), .rsp_echo_clock(rsp_echo_clock),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser state as this testbench tracks it.
   logic [4:0] cfg_listen = 5'd0;
   logic       cfg_fwd_clock = 1'b0;
   bit         sx_active = 1'b0;
   int         sx_count = 0;
   logic [7:0] status_byte = 8'h00;
   bit         have_first = 1'b0;
   logic [7:0] first_byte = 8'h00;
   logic [7:0] bank_lsb = BANK_NONE;
   logic       transport_on = 1'b0;

   result_type pending_events[$];
   int         mismatches = 0;
   int         bytes_sent = 0;
   int         send_idle_pct = 28;
   int         rsp_idle_pct = 55;
   int         rsp_hold_cycles = 0;
   logic [7:0] last_status = 8'h00;
   int         chunk_no = 0;
   logic [4:0] listen_plan [6] = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd17, 5'd0};

   function automatic bit parse_midi_byte(input logic [7:0] b, output result_type ev);
      bit         hit;
      bit         one_data;
      logic [3:0] kind;
      logic [7:0] d0;
      logic [6:0] pc;
      hit = 1'b0;
      ev = '0;
      if (b >= BYTE_CLOCK) begin
         case (b)
            BYTE_CLOCK: begin
               hit = 1'b1;
               ev.event_res = EV_CLOCK;
               ev.echo_clock = cfg_fwd_clock;
            end
            BYTE_START, BYTE_CONTINUE: begin
               hit = 1'b1;
               transport_on = 1'b1;
               ev.event_res = EV_START;
            end
            BYTE_STOP: begin
               hit = 1'b1;
               transport_on = 1'b0;
               ev.event_res = EV_STOP;
            end
            default: hit = 1'b0;
         endcase
      end else if (b == BYTE_SX_START) begin
         sx_active = 1'b1;
         sx_count = 0;
      end else if (b == BYTE_SX_END) begin
         if (sx_active) begin
            hit = 1'b1;
            ev.event_res = EV_SX_END;
            ev.sysex_index = sx_count[SX_IDX_W-1:0];
         end
         sx_active = 1'b0;
      end else if (sx_active) begin
         // Bytes past the capacity are dropped without an event.
         if (sx_count < SYSEX_CAPACITY) begin
            hit = 1'b1;
            ev.event_res = EV_SX_BYTE;
            ev.data_value = b;
            ev.sysex_index = sx_count[SX_IDX_W-1:0];
            sx_count++;
         end
      end else if (b[7]) begin
         status_byte = b;
         have_first = 1'b0;
      end else if (status_byte != 8'h00) begin
         kind = status_byte[7:4];
         one_data = (kind == TYPE_PROGRAM) || (kind == TYPE_PRESSURE);
         if (!one_data && !have_first) begin
            first_byte = b;
            have_first = 1'b1;
         end else begin
            d0 = one_data ? b : first_byte;
            have_first = 1'b0;
            if (cfg_listen == 5'd0 || cfg_listen == {1'b0, status_byte[3:0]} + 5'd1) begin
               if (kind == TYPE_NOTE_ON && b != 8'h00) begin
                  hit = 1'b1;
                  ev.event_res = EV_NOTE;
                  ev.data_value = d0;
                  ev.velocity = b[6:0];
                  ev.accent = (b[6:0] >= ACCENT_VEL);
               end else if (kind == TYPE_CC) begin
                  if (d0 == CC_BANK_LSB) bank_lsb = b;
               end else if (kind == TYPE_PROGRAM) begin
                  pc = d0[6:0];
                  hit = 1'b1;
                  ev.event_res = EV_PROG;
                  ev.data_value = {4'd0, pc[3:0]};
                  ev.variation = (bank_lsb <= 8'd1) ? bank_lsb[0] : pc[4];
               end
            end
         end
      end
      ev.transport = transport_on;
      return hit;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            $error("event_res: expected no result, got %0d", rsp_event_res);
            mismatches++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_res", 32'(want.event_res), 32'(rsp_event_res));
            check_field("data_value", 32'(want.data_value), 32'(rsp_data_value));
            check_field("velocity", 32'(want.velocity), 32'(rsp_velocity));
            check_field("accent", 32'(want.accent), 32'(rsp_accent));
            check_field("variation", 32'(want.variation), 32'(rsp_variation));
            check_field("sysex_index", 32'(want.sysex_index), 32'(rsp_sysex_index));
            check_field("transport", 32'(want.transport), 32'(rsp_transport));
            check_field("echo_clock", 32'(want.echo_clock), 32'(rsp_echo_clock));
         end
      end
   end

   task automatic offer_byte(input logic [7:0] b);
      result_type ev;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_value <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (parse_midi_byte(b, ev)) pending_events.push_back(ev);
   endtask

   // Real-time bytes may land anywhere in the stream.
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < 7)
         offer_byte(8'($urandom_range(1) ? BYTE_CLOCK : $urandom_range(BYTE_CLOCK, 8'hFF)));
      offer_byte(b);
   endtask

   // Called right after an accepted item or at an edge; drops valid and waits for the pipe.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [4:0] lc, input logic fc);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_LISTEN_CHANNEL, 2'b00};
      csr_pwdata <= {27'd0, lc};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_paddr <= {REG_FORWARD_CLOCK, 2'b00};
      csr_pwdata <= {31'd0, fc};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cfg_listen = lc;
      cfg_fwd_clock = fc;
   endtask

   function automatic logic [7:0] sysex_payload();
      int r;
      r = $urandom_range(99);
      if (r < 85) return 8'($urandom_range(0, 127));
      if (r < 93) return 8'($urandom_range(8'h80, 8'hEF));
      return 8'($urandom_range(8'hF1, 8'hF6));
   endfunction

   function automatic logic [3:0] pick_channel();
      if (cfg_listen >= 5'd1 && cfg_listen <= 5'd16 && $urandom_range(99) < 75)
         return 4'(cfg_listen - 5'd1);
      return 4'($urandom_range(0, 15));
   endfunction

   // Leaves out the status byte now and then so that running status gets used.
   task automatic send_status(input logic [7:0] s);
      if (!(s == last_status && $urandom_range(99) < 60)) send_byte(s);
      last_status = s;
   endtask

   task automatic send_random_message(input logic [3:0] chan);
      int pick;
      int n;
      int r;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_status({TYPE_NOTE_ON, chan});
         send_byte(8'($urandom_range(0, 127)));
         r = $urandom_range(9);
         if (r == 0) send_byte(8'h00);
         else if (r < 4) send_byte(8'($urandom_range(100, 127)));
         else send_byte(8'($urandom_range(1, 99)));
      end else if (pick < 42) begin
         send_status({TYPE_CC, chan});
         send_byte(8'($urandom_range(1) ? CC_BANK_LSB : $urandom_range(0, 127)));
         send_byte(8'($urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(0, 127)));
      end else if (pick < 55) begin
         send_status({TYPE_PROGRAM, chan});
         send_byte(8'($urandom_range(0, 127)));
      end else if (pick < 60) begin
         send_status({TYPE_PRESSURE, chan});
         send_byte(8'($urandom_range(0, 127)));
      end else if (pick < 66) begin
         r = $urandom_range(2);
         send_status({(r == 0) ? 4'h8 : (r == 1) ? 4'hA : 4'hE, chan});
         send_byte(8'($urandom_range(0, 127)));
         send_byte(8'($urandom_range(0, 127)));
      end else if (pick < 78) begin
         send_byte(BYTE_SX_START);
         n = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
         repeat (n) send_byte(sysex_payload());
         r = $urandom_range(99);
         if (r < 80) begin
            send_byte(BYTE_SX_END);
         end else if (r < 90) begin
            send_byte(BYTE_SX_START);
            send_byte(sysex_payload());
            send_byte(BYTE_SX_END);
         end
      end else if (pick < 84) begin
         last_status = 8'($urandom_range(8'hF1, 8'hF6));
         send_byte(last_status);
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 127)));
      end else if (pick < 90) begin
         send_byte(8'($urandom_range(1) ? BYTE_SX_END : $urandom_range(0, 127)));
      end else begin
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_data_before_status();
      offer_byte(8'h00);
      offer_byte(8'h7F);
   endtask

   task automatic test_realtime_bytes();
      offer_byte(BYTE_CLOCK);
      offer_byte(BYTE_START);
      offer_byte(BYTE_STOP);
      offer_byte(BYTE_CONTINUE);
      offer_byte(8'hF9);
      offer_byte(8'hFF);
      settle_pipeline();
      write_config(5'd0, 1'b1);
      offer_byte(BYTE_CLOCK);
      offer_byte(BYTE_STOP);
   endtask

   task automatic test_sysex_framing();
      offer_byte(BYTE_SX_END);
      offer_byte(BYTE_SX_START);
      offer_byte(8'h00);
      offer_byte(8'h80);
      offer_byte(8'hF6);
      offer_byte(BYTE_CLOCK);
      offer_byte(BYTE_SX_START);
      offer_byte(8'h7F);
      offer_byte(BYTE_SX_END);
   endtask

   task automatic test_channel_voice();
      offer_byte({TYPE_NOTE_ON, 4'h0});
      offer_byte(8'h3C);
      offer_byte(8'h00);
      offer_byte(8'h7F);
      offer_byte(8'd99);
      offer_byte(8'h00);
      offer_byte(8'd100);
      // No bank yet, so bit 4 of the program number picks the variation.
      offer_byte({TYPE_PROGRAM, 4'hF});
      offer_byte(8'h10);
      offer_byte({TYPE_CC, 4'h0});
      offer_byte(CC_BANK_LSB);
      offer_byte(8'h01);
      offer_byte({TYPE_PROGRAM, 4'h0});
      offer_byte(8'h0F);
      offer_byte({TYPE_PRESSURE, 4'h0});
      offer_byte(8'h40);
      offer_byte(8'hF1);
      offer_byte(8'h10);
   endtask

   task automatic test_sysex_overflow();
      offer_byte(BYTE_SX_START);
      repeat (SYSEX_CAPACITY + 40) offer_byte(8'($urandom_range(0, 127)));
      offer_byte(BYTE_SX_END);
      settle_pipeline();
   endtask

   // The receiver stops for a long stretch while clock items keep coming.
   task automatic test_backpressure();
      rsp_hold_cycles = 150;
      repeat (40) offer_byte(BYTE_CLOCK);
      settle_pipeline();
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
      int start;
      logic [4:0] lc;
      send_idle_pct = sender_idle;
      rsp_idle_pct = receiver_idle;
      repeat (4) begin
         lc = (chunk_no < 6) ? listen_plan[chunk_no] : 5'($urandom_range(0, 17));
         settle_pipeline();
         write_config(lc, chunk_no[0]);
         chunk_no++;
         start = bytes_sent;
         while (bytes_sent - start < 40) send_random_message(pick_channel());
      end
      settle_pipeline();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_data_before_status();
      test_realtime_bytes();
      test_sysex_framing();
      test_channel_voice();
      test_random_traffic(28, 55);
      test_sysex_overflow();
      test_random_traffic(55, 28);
      test_random_traffic(0, 0);
      test_backpressure();
      settle_pipeline();
      if (mismatches == 0 && pending_events.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mbsp_pkg.sv
rtl/core/mbsp_decode.sv
rtl/core/midi_byte_stream_parser_unit.sv
tb/midi_byte_stream_parser_unit_test.sv
